// ===== rtl/nsr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nsr_pkg: shared types and constants
// Field widths, action codes and the entry and control structs used by the
// sorted retainer cells and the top level.
// ---------------------------------------------------------------------------
package nsr_pkg;

	localparam int KEY_W = 40;
	localparam int TAG_W = 16;
	localparam int CFG_W = 7;
	localparam int IDX_W = 6;
	localparam int OUT_CNT_W = 7;

	localparam logic ACT_OFFER = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam logic [CFG_W-1:0] KEEP_COUNT_RST = CFG_W'(10);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} nsr_entry_t;

	// broadcast to every cell for one item
	typedef struct packed {
		logic       write_en;
		logic       full;
		nsr_entry_t new_ent;
	} nsr_ctrl_t;

endpackage : nsr_pkg
`default_nettype wire

// ===== rtl/newest_n_sorted_retainer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// newest_n_sorted_retainer: top-k sorted insertion buffer
// The result strobe done rises in the cycle after start is taken.
// Throughput: one item per cycle; busy never rises, as the row of
// compare-and-shift cells writes each insert straight into its registers.
// Reset clears the entry count and sets keep_count to 10; entry contents are
// left as they are. The receiver cannot stall, so results are never held.
// ---------------------------------------------------------------------------
module newest_n_sorted_retainer
	import nsr_pkg::*;
#(
	parameter int CAPACITY = 64
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 action,
	input  wire logic [KEY_W-1:0]     event_key,
	input  wire logic [TAG_W-1:0]     event_tag,
	input  wire logic [IDX_W-1:0]     read_index,
	output logic                      done,
	output logic [OUT_CNT_W-1:0]      stored_count,
	output logic                      accepted,
	output logic                      entry_valid,
	output logic [KEY_W-1:0]          entry_key,
	output logic [TAG_W-1:0]          entry_tag
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0] keep_count_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] total_d;
	logic [CMP_W-1:0] lim;
	logic             take;
	logic             is_offer;
	logic             place;
	logic             rd_valid;
	nsr_ctrl_t        ctrl;
	nsr_entry_t       rd_ent;

	logic       le_v   [CAPACITY];
	logic       use_v  [CAPACITY];
	nsr_entry_t ent_v  [CAPACITY];

	assign busy = 1'b0;
	assign take = start && !busy;
	assign is_offer = take && (action == ACT_OFFER);

	// clamp the limit to the table size
	assign lim = (CMP_W'(keep_count_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
		: CMP_W'(keep_count_q);

	// decide whether the offer lands
	always_comb begin
		ctrl.full          = CMP_W'(total_q) >= lim;
		ctrl.new_ent.key   = event_key;
		ctrl.new_ent.tag   = event_tag;
		place              = is_offer && (!ctrl.full || le_v[0]);
		ctrl.write_en      = place;
		total_d            = total_q;
		if (place && !ctrl.full) begin
			total_d = total_q + CNT_W'(1);
		end
	end

	// build the row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic       le_l;
		logic       le_r;
		nsr_entry_t ent_l;
		nsr_entry_t ent_r;

		assign use_v[i] = CMP_W'(i) < CMP_W'(total_q);

		if (i == 0) begin : g_first
			assign le_l  = 1'b1;
			assign ent_l = ctrl.new_ent;
		end else begin : g_mid_l
			assign le_l  = le_v[i-1];
			assign ent_l = ent_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign le_r  = 1'b0;
			assign ent_r = ctrl.new_ent;
		end else begin : g_mid_r
			assign le_r  = le_v[i+1];
			assign ent_r = ent_v[i+1];
		end

		nsr_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.in_use    (use_v[i]),
			.le_left   (le_l),
			.le_right  (le_r),
			.ent_left  (ent_l),
			.ent_right (ent_r),
			.le        (le_v[i]),
			.ent       (ent_v[i])
		);
	end

	// select the entry at the read index
	assign rd_valid = CMP_W'(read_index) < CMP_W'(total_q);

	always_comb begin
		rd_ent = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMP_W'(i) == CMP_W'(read_index)) begin
				rd_ent = rd_ent | ent_v[i];
			end
		end
	end

	// hold configuration and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_COUNT_RST;
			total_q      <= '0;
			done         <= 1'b0;
		end else begin
			if (cfg_we) begin
				keep_count_q <= cfg_wdata;
			end
			if (take) begin
				total_q <= total_d;
			end
			done <= take;
		end
	end

	// register the result item
	always_ff @(posedge clk) begin
		if (take) begin
			stored_count <= OUT_CNT_W'(total_d);
			accepted     <= place;
			if (action == ACT_READ && rd_valid) begin
				entry_valid <= 1'b1;
				entry_key   <= rd_ent.key;
				entry_tag   <= rd_ent.tag;
			end else begin
				entry_valid <= 1'b0;
				entry_key   <= '0;
				entry_tag   <= '0;
			end
		end
	end

endmodule : newest_n_sorted_retainer
`default_nettype wire

// ===== rtl/nsr_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nsr_cell: one table position
// Holds one entry, compares it with the offered key and takes the new item,
// its left neighbour, its right neighbour, or holds, as the insert demands.
// ---------------------------------------------------------------------------
module nsr_cell
	import nsr_pkg::*;
(
	input  wire logic       clk,
	input  wire nsr_ctrl_t  ctrl,
	input  wire logic       in_use,
	input  wire logic       le_left,
	input  wire logic       le_right,
	input  wire nsr_entry_t ent_left,
	input  wire nsr_entry_t ent_right,
	output logic            le,
	output nsr_entry_t      ent
);

	nsr_entry_t ent_q;
	nsr_entry_t ent_d;

	// flag a stored entry at or below the offered key
	assign le  = in_use && (ent_q.key <= ctrl.new_ent.key);
	assign ent = ent_q;

	// choose the next content
	always_comb begin
		ent_d = ent_q;
		if (ctrl.full) begin
			// drop the smallest: slide lower part down, place below first greater
			if (le_right) begin
				ent_d = ent_right;
			end else if (le) begin
				ent_d = ctrl.new_ent;
			end
		end else begin
			// open a gap: shift the upper part up
			if (!le) begin
				if (le_left) begin
					ent_d = ctrl.new_ent;
				end else begin
					ent_d = ent_left;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.write_en) begin
			ent_q <= ent_d;
		end
	end

endmodule : nsr_cell
`default_nettype wire
